FILE: sv/euler_to_rotation_matrix_defines.svh
// assertion macros used by the euler to rotation matrix top level
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH

// property that must hold at every clock while out of reset
`define E2R_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// implication checked on the next cycle
`define E2R_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/e2r_pkg.sv
// package: types, constants and helpers for the euler to rotation matrix block
`default_nettype none
package e2r_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int OUT_FRAC_BITS_DEF   = 14;
    localparam int TRIG_ITER_DEF       = 16;

    localparam int QF = 30;
    // q2.30 working word plus guard bits for reduction and products
    localparam int WW = 36;

    localparam logic signed [WW-1:0] Q_PI      = 36'sd3373259426;
    localparam logic signed [WW-1:0] Q_TWO_PI  = 36'sd6746518852;
    localparam logic signed [WW-1:0] Q_HALF_PI = 36'sd1686629713;
    localparam logic signed [WW-1:0] Q_GAIN    = 36'sd652032874;
    localparam logic signed [WW-1:0] Q_ONE     = 36'sd1073741824;

    typedef logic signed [WW-1:0] word_t;

    typedef struct packed {
        logic signed [15:0] angle_z;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_x;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } out_item_t;

    typedef struct packed {
        word_t s;
        word_t c;
    } sc_t;

    function automatic word_t atan_q(input int i);
        word_t r;
        case (i)
            0: r = 36'sd843314857;
            1: r = 36'sd497837829;
            2: r = 36'sd263043837;
            3: r = 36'sd133525159;
            4: r = 36'sd67021687;
            5: r = 36'sd33543516;
            6: r = 36'sd16775851;
            7: r = 36'sd8388437;
            8: r = 36'sd4194283;
            9: r = 36'sd2097149;
            default: begin
                if (i <= 30) r = word_t'(64'sd1 <<< (30 - i));
                else r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic word_t clamp_one(input word_t v);
        word_t r;
        if (v > Q_ONE) r = Q_ONE;
        else if (v < -Q_ONE) r = -Q_ONE;
        else r = v;
        return r;
    endfunction

    // q2.30 product, rounded half up; operands limited to +-1.0 in magnitude
    function automatic word_t qmul(input word_t a, input word_t b);
        logic signed [31:0] a32;
        logic signed [31:0] b32;
        logic signed [63:0] p;
        a32 = a[31:0];
        b32 = b[31:0];
        p = a32 * b32 + (64'sd1 <<< (QF - 1));
        return word_t'(p >>> QF);
    endfunction

endpackage
`default_nettype wire

FILE: sv/e2r_sincos.sv
// pipelined angle reduction and cordic sine/cosine for one angle
`default_nettype none
module e2r_sincos
    import e2r_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [15:0] angle,
    output sc_t              sc
);
    localparam int NS = TRIG_ITERATIONS;
    // the angle in q2.30 fits within +-2^MAG_BITS; 2*pi exceeds 2^32, so the
    // quotient of the reduction stays below 2^RED_K
    localparam int MAG_BITS = QF - ANGLE_FRAC_BITS + 15;
    localparam int RED_K    = (MAG_BITS > 32) ? (MAG_BITS - 32) : 0;

    word_t t_reg;
    logic  neg0_reg;

    word_t t_next;
    logic  neg_next;

    always_comb begin
        logic signed [47:0] w;
        logic signed [47:0] r;
        logic signed [47:0] tp;
        logic signed [47:0] thp;
        logic signed [47:0] tw;
        w = 48'(signed'(angle)) <<< (QF - ANGLE_FRAC_BITS);
        tp = 48'(Q_TWO_PI);
        thp = 48'(Q_PI);
        // truncated remainder by restoring compare and subtract
        r = (w < 0) ? -w : w;
        for (int k = RED_K - 1; k >= 0; k--) begin
            if (r >= (tp <<< k)) r = r - (tp <<< k);
        end
        if (w < 0) r = -r;
        if (r < 0) r = r + tp;
        if (r > thp) r = r - tp;
        tw = r;
        neg_next = 1'b0;
        if (tw > 48'(Q_HALF_PI)) begin
            tw = tw - thp;
            neg_next = 1'b1;
        end else if (tw < -48'(Q_HALF_PI)) begin
            tw = tw + thp;
            neg_next = 1'b1;
        end
        t_next = tw[WW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg    <= t_next;
            neg0_reg <= neg_next;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        word_t x_reg;
        word_t y_reg;
        word_t z_reg;
        logic  ng_reg;
        word_t x_in;
        word_t y_in;
        word_t z_in;
        logic  ng_in;

        if (i == 0) begin : g_in
            assign x_in  = Q_GAIN;
            assign y_in  = '0;
            assign z_in  = t_reg;
            assign ng_in = neg0_reg;
        end else begin : g_in
            assign x_in  = g_stage[i-1].x_reg;
            assign y_in  = g_stage[i-1].y_reg;
            assign z_in  = g_stage[i-1].z_reg;
            assign ng_in = g_stage[i-1].ng_reg;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_in >= 0) begin
                    x_reg <= x_in - (y_in >>> i);
                    y_reg <= y_in + (x_in >>> i);
                    z_reg <= z_in - atan_q(i);
                end else begin
                    x_reg <= x_in + (y_in >>> i);
                    y_reg <= y_in - (x_in >>> i);
                    z_reg <= z_in + atan_q(i);
                end
                ng_reg <= ng_in;
            end
        end
    end

    sc_t sc_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg.c <= clamp_one(g_stage[NS-1].ng_reg ? -g_stage[NS-1].x_reg
                                                       : g_stage[NS-1].x_reg);
            sc_reg.s <= clamp_one(g_stage[NS-1].ng_reg ? -g_stage[NS-1].y_reg
                                                       : g_stage[NS-1].y_reg);
        end
    end
    assign sc = sc_reg;
endmodule
`default_nettype wire

FILE: sv/e2r_matrix.sv
// three-stage product network forming the nine matrix elements
`default_nettype none
module e2r_matrix
    import e2r_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic en,
    input  wire sc_t  scz,
    input  wire sc_t  scy,
    input  wire sc_t  scx,
    output out_item_t res
);
    localparam int SH = QF - OUT_FRAC_BITS;

    function automatic logic [15:0] to_out(input word_t v);
        logic signed [WW:0] r;
        logic signed [WW:0] lim;
        logic signed [WW:0] half;
        lim = (WW+1)'(1) <<< OUT_FRAC_BITS;
        half = (WW+1)'(1) <<< (SH - 1);
        r = (WW+1)'(v);
        if (SH > 0) r = (r + half) >>> SH;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    // stage a: first-level products
    word_t czsy_reg, szsy_reg, czcy_reg, szcy_reg, cysx_reg, cycx_reg;
    word_t szcx_reg, szsx_reg, czcx_reg, czsx_reg, nsy_reg, sx_a_reg, cx_a_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            czsy_reg <= qmul(scz.c, scy.s);
            szsy_reg <= qmul(scz.s, scy.s);
            czcy_reg <= qmul(scz.c, scy.c);
            szcy_reg <= qmul(scz.s, scy.c);
            cysx_reg <= qmul(scy.c, scx.s);
            cycx_reg <= qmul(scy.c, scx.c);
            szcx_reg <= qmul(scz.s, scx.c);
            szsx_reg <= qmul(scz.s, scx.s);
            czcx_reg <= qmul(scz.c, scx.c);
            czsx_reg <= qmul(scz.c, scx.s);
            nsy_reg  <= -scy.s;
            sx_a_reg <= scx.s;
            cx_a_reg <= scx.c;
        end
    end

    // stage b: triple products and sums
    word_t v_reg [9];
    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0] <= czcy_reg;
            v_reg[1] <= qmul(czsy_reg, sx_a_reg) - szcx_reg;
            v_reg[2] <= qmul(czsy_reg, cx_a_reg) + szsx_reg;
            v_reg[3] <= szcy_reg;
            v_reg[4] <= qmul(szsy_reg, sx_a_reg) + czcx_reg;
            v_reg[5] <= qmul(szsy_reg, cx_a_reg) - czsx_reg;
            v_reg[6] <= nsy_reg;
            v_reg[7] <= cysx_reg;
            v_reg[8] <= cycx_reg;
        end
    end

    // stage c: round and saturate
    out_item_t res_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.m00 <= to_out(v_reg[0]);
            res_reg.m01 <= to_out(v_reg[1]);
            res_reg.m02 <= to_out(v_reg[2]);
            res_reg.m10 <= to_out(v_reg[3]);
            res_reg.m11 <= to_out(v_reg[4]);
            res_reg.m12 <= to_out(v_reg[5]);
            res_reg.m20 <= to_out(v_reg[6]);
            res_reg.m21 <= to_out(v_reg[7]);
            res_reg.m22 <= to_out(v_reg[8]);
        end
    end
    assign res = res_reg;
endmodule
`default_nettype wire

FILE: sv/euler_to_rotation_matrix.sv
// top level: euler zyx angles to rotation matrix, fully pipelined
//
// input channel s_*: one transfer carries angle_z, angle_y, angle_x as
// signed q3.13 radians (any value, reduced modulo 2*pi internally)
// output channel m_*: one transfer carries the nine q2.14 elements of
// rz*ry*rx, each rounded and saturated to +-1.0
// pipeline stages from input transfer to m_valid: one reduction stage,
// one stage per cordic iteration, one sign/clamp stage and three product
// stages
// throughput: one transfer per cycle while m_ready keeps up; the single
// enable-gated pipeline chain advances whenever the output slot is free
// when the receiver stalls, the whole pipe freezes in place and nothing
// is dropped or duplicated; s_ready drops only when the last stage holds
// a result that is not taken
// reset clears all valid bits; payload registers are not reset
`default_nettype none
`include "euler_to_rotation_matrix_defines.svh"
module euler_to_rotation_matrix
    import e2r_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);
    // reduction + iterations + clamp + three product stages
    localparam int DEPTH = TRIG_ITERATIONS + 5;

    logic [DEPTH-1:0] vld_reg;
    logic             en;

    // advance when the last slot is empty or being drained
    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    sc_t scz, scy, scx;

    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_z (
        .aclk(aclk), .en(en), .angle(s_data.angle_z), .sc(scz));
    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_y (
        .aclk(aclk), .en(en), .angle(s_data.angle_y), .sc(scy));
    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_x (
        .aclk(aclk), .en(en), .angle(s_data.angle_x), .sc(scx));

    e2r_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
        .aclk(aclk), .en(en), .scz(scz), .scy(scy), .scx(scx), .res(m_data));

    // a stalled result keeps the pipe frozen
    `E2R_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    // the input is refused only while a result waits
    `E2R_ASSERT(a_ready, s_ready || (m_valid && !m_ready), "input refused without back pressure")
    // an accepted transfer enters the first valid stage
    `E2R_ASSERT_NEXT(a_enter, s_valid && s_ready, vld_reg[0], "accepted transfer lost")
endmodule
`default_nettype wire

FILE: test/tb_euler_to_rotation_matrix.sv
// testbench for the euler zyx to rotation matrix block
`timescale 1ns / 1ps
module tb_euler_to_rotation_matrix;
    import e2r_pkg::*;

    localparam int ANG_SHIFT = 30 - ANGLE_FRAC_BITS_DEF;
    localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS_DEF;
    localparam int LATENCY = TRIG_ITER_DEF + 5;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint ONE_Q30 = 64'sd1 <<< 30;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    out_item_t matrix_q[$];
    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int idle_cycles = 0;
    bit rx_hold = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    euler_to_rotation_matrix uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // ---------------- predictor ----------------

    function automatic longint shr_floor(input longint v, input int sh);
        return v >>> sh;
    endfunction

    function automatic longint lim_one(input longint v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    function automatic longint arctan_step(input int i);
        longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return head[i];
        if (i <= 30) return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    // reduce to (-pi, pi], fold into +-pi/2, then rotate the cordic vector
    task automatic angle_sincos(input logic signed [15:0] ang,
                                output longint sn, output longint cs);
        longint t, x, y, z, nx;
        bit flip;
        t = longint'(ang) <<< ANG_SHIFT;
        t = t % TWO_PI_Q30;
        if (t < 0) t += TWO_PI_Q30;
        if (t > PI_Q30) t -= TWO_PI_Q30;
        flip = 1'b0;
        if (t > HALF_PI_Q30) begin
            t -= PI_Q30;
            flip = 1'b1;
        end else if (t < -HALF_PI_Q30) begin
            t += PI_Q30;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        z = t;
        for (int i = 0; i < TRIG_ITER_DEF; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z -= arctan_step(i);
            end else begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z += arctan_step(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = lim_one(x);
        sn = lim_one(y);
    endtask

    function automatic longint mul_q30(input longint a, input longint b);
        return shr_floor(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic signed [15:0] to_q14(input longint v);
        longint r, lim;
        lim = 64'sd1 <<< OUT_FRAC_BITS_DEF;
        r = shr_floor(v + (64'sd1 <<< (OUT_SHIFT - 1)), OUT_SHIFT);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    task automatic rotation_matrix(input in_item_t a, output out_item_t m);
        longint sz, cz, sy, cy, sx, cx, czsy, szsy;
        angle_sincos(a.angle_z, sz, cz);
        angle_sincos(a.angle_y, sy, cy);
        angle_sincos(a.angle_x, sx, cx);
        czsy = mul_q30(cz, sy);
        szsy = mul_q30(sz, sy);
        m.m00 = to_q14(mul_q30(cz, cy));
        m.m01 = to_q14(mul_q30(czsy, sx) - mul_q30(sz, cx));
        m.m02 = to_q14(mul_q30(czsy, cx) + mul_q30(sz, sx));
        m.m10 = to_q14(mul_q30(sz, cy));
        m.m11 = to_q14(mul_q30(szsy, sx) + mul_q30(cz, cx));
        m.m12 = to_q14(mul_q30(szsy, cx) - mul_q30(cz, sx));
        m.m20 = to_q14(-sy);
        m.m21 = to_q14(mul_q30(cy, sx));
        m.m22 = to_q14(mul_q30(cy, cx));
    endtask

    // ---------------- driving ----------------

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one input transfer; valid stays up across back-to-back items
    task automatic send_angles(input in_item_t a, input bit gaps);
        out_item_t m;
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rotation_matrix(a, m);
        matrix_q.push_back(m);
        n_sent++;
    endtask

    task automatic end_of_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic in_item_t angles(input int z, input int y, input int x);
        in_item_t a;
        a.angle_z = z[15:0];
        a.angle_y = y[15:0];
        a.angle_x = x[15:0];
        return a;
    endfunction

    // angle near a multiple of pi/2, where the fold and the clamp act (multiples beyond +-2 wrap in 16 bits)
    function automatic int near_quadrant();
        int q;
        q = $urandom_range(0, 8) - 4;
        return q * 12868 + int'($urandom_range(0, 8)) - 4;
    endfunction

    // ---------------- receiver and checking ----------------

    always @(posedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 50 && !m_ready);
        end
    end

    task automatic force_stall();
        rx_hold <= 1'b1;
        repeat ($urandom_range(10, 40)) begin
            @(posedge aclk);
        end
        rx_hold <= 1'b0;
    endtask

    // long receiver stalls now and then
    initial begin
        forever begin
            repeat ($urandom_range(200, 600)) @(posedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                force_stall();
            end
        end
    end

    task automatic cmp_elem(input string nm, input logic signed [15:0] exp_v,
                            input logic signed [15:0] act_v, inout bit bad);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, nm, exp_v, act_v);
            bad = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t e;
        bit bad;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (matrix_q.size() == 0) begin
                    $display("%0t unexpected output transfer", $time);
                    n_errors++;
                end else begin
                    e = matrix_q.pop_front();
                    bad = 1'b0;
                    cmp_elem("m00", e.m00, m_data.m00, bad);
                    cmp_elem("m01", e.m01, m_data.m01, bad);
                    cmp_elem("m02", e.m02, m_data.m02, bad);
                    cmp_elem("m10", e.m10, m_data.m10, bad);
                    cmp_elem("m11", e.m11, m_data.m11, bad);
                    cmp_elem("m12", e.m12, m_data.m12, bad);
                    cmp_elem("m20", e.m20, m_data.m20, bad);
                    cmp_elem("m21", e.m21, m_data.m21, bad);
                    cmp_elem("m22", e.m22, m_data.m22, bad);
                    if (bad) n_errors++;
                    n_checked++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog expired, %0d results outstanding",
                         $time, matrix_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        int ext[6] = '{-32768, -32767, -1, 0, 1, 32767};
        send_angles(angles(0, 0, 0), 1'b0);
        for (int i = 0; i < 6; i++) send_angles(angles(ext[i], ext[5 - i], ext[(i + 2) % 6]), 1'b0);
        // quarter and half turns exercise the fold and the clamp to one
        send_angles(angles(12868, 0, 0), 1'b0);
        send_angles(angles(0, 12868, 0), 1'b0);
        send_angles(angles(0, -12868, 0), 1'b0);
        send_angles(angles(0, 0, 25736), 1'b0);
        send_angles(angles(25735, -25736, 25737), 1'b0);
        send_angles(angles(12867, 12869, -12869), 1'b0);
        // gimbal lock with all three axes turned
        send_angles(angles(4000, 12868, -7000), 1'b0);
        // beyond half a turn, reduced into (-pi, pi]
        send_angles(angles(51472, -51472, 30000), 1'b0);
        send_angles(angles(-30000, 20000, -20000), 1'b0);
        end_of_burst();
    endtask

    task automatic test_random();
        int sel;
        for (int n = 0; n < 1200; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                send_angles(angles($urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535)), 1'b1);
            end else if (sel < 9) begin
                send_angles(angles(near_quadrant(), near_quadrant(), near_quadrant()), 1'b1);
            end else begin
                send_angles(angles($urandom_range(0, 1) ? 32767 : -32768,
                                   $urandom_range(0, 65535),
                                   $urandom_range(0, 1) ? -32768 : 32767), 1'b1);
            end
            if ($urandom_range(0, 49) == 0) end_of_burst();
        end
        end_of_burst();
    endtask

    task automatic drain();
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        drain();
        $display("%0d angle triples sent, %0d matrices checked", n_sent, n_checked);
        $display("covered full-range, quadrant-edge and wrap-around angles with gaps and stalls");
        if (n_errors == 0 && matrix_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/e2r_pkg.sv
sv/e2r_sincos.sv
sv/e2r_matrix.sv
sv/euler_to_rotation_matrix.sv
test/tb_euler_to_rotation_matrix.sv
